// ----- rtl/gtb_pkg.sv -----
// Package for the gateway table balancer: the command and result transfer types,
// the slot record, the action and status codes, and the default sizes.
// No dependencies.
package gtb_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int TIE_COUNTERS_DEF  = 8;
    localparam logic [31:0] STALE_TIMEOUT_RST = 32'd30000;

    localparam logic [2:0] ACT_UPSERT  = 3'd0;
    localparam logic [2:0] ACT_TOUCH   = 3'd1;
    localparam logic [2:0] ACT_PRUNE   = 3'd2;
    localparam logic [2:0] ACT_PICK_RR = 3'd3;
    localparam logic [2:0] ACT_PICK_ID = 3'd4;
    localparam logic [2:0] ACT_PICK_ZN = 3'd5;
    localparam logic [2:0] ACT_COUNT   = 3'd6;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] gateway_id;
        logic [31:0] zone_id;
        logic [7:0]  game_type;
        logic [31:0] online_count;
        logic [47:0] time_ms;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] picked_id;
        logic [31:0] picked_zone;
        logic [7:0]  picked_game_type;
        logic [31:0] picked_online;
        logic [47:0] picked_heartbeat;
        logic [4:0]  zone_count;
    } t_result;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] zone;
        logic [7:0]  gtype;
        logic [31:0] load;
        logic [47:0] hb;
    } t_slot;

endpackage

// ----- rtl/gtb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/gateway_table_balancer.sv -----
// Top level of the gateway table balancer: sequencer, slot table and tie counters.
// Depends on gtb_pkg and gtb_ram.
//
// Usage
//   Command channel: present i_cmd and raise start; the transfer happens at the
//   clock edge where start is high and busy is low. busy stays high while the
//   command is worked on.
//   Result channel: exactly one result per command, shown on o_result for one
//   cycle with o_strobe high. The receiver cannot stall it; busy is already low
//   in the strobe cycle, so the next command may start there.
//   Config: i_cfg_we/i_cfg_wdata writes stale_timeout; write only while idle.
// Operation
//   Every pass over the N = TABLE_ENTRIES slots walks one slot at a time through the
//   single read port of the slot RAM; the tie counter lookup walks the T = TIE_COUNTERS counters.
//   Upsert, touch, prune, pick by id, count: one pass over the table, then the write or result.
//   Unknown action, round robin on an empty table: result without leaving idle.
//   Round robin pick: rank search over the live slots through the one RAM port.
//   Zone pick: a least-load pass, the tie counter lookup, a pass counting the ties,
//   iterative modulo of the tie counter, then the rank search.
// Reset
//   Synchronous, active low: table and tie counters empty, cursor zero,
//   stale_timeout 30000. RAM contents are not cleared; valid bits guard them.
module gateway_table_balancer
    import gtb_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int TIE_COUNTERS  = TIE_COUNTERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_cmd        i_cmd,
    output logic        o_strobe,
    output t_result     o_result,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);
    localparam int IW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int TW  = (TIE_COUNTERS > 1) ? $clog2(TIE_COUNTERS) : 1;
    localparam int CW  = $clog2(TABLE_ENTRIES + 1);
    localparam int SW  = $bits(t_slot);
    localparam int TEW = 40 + CW;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SCAN  = 10'b0000000010,
        S_FIN   = 10'b0000000100,
        S_TIE   = 10'b0000001000,
        S_TFIN  = 10'b0000010000,
        S_MOD   = 10'b0000100000,
        S_OUTER = 10'b0001000000,
        S_INNER = 10'b0010000000,
        S_RANK  = 10'b0100000000,
        S_WRITE = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    t_cmd   r_in, n_in;
    logic [31:0] r_timeout;
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic [TIE_COUNTERS-1:0]  r_tvalid, n_tvalid;
    logic [CW-1:0] r_count, n_count, r_cursor, n_cursor;
    logic [IW-1:0] r_idx, n_idx, r_k, n_k, r_hit_idx, n_hit_idx, r_free_idx, n_free_idx;
    logic          r_ph, n_ph, r_hit, n_hit, r_free, n_free, r_new, n_new;
    logic          r_any, n_any, r_pass, n_pass;
    logic [31:0]   r_best, n_best;
    logic [CW-1:0] r_cnt, n_cnt, r_ties, n_ties, r_want, n_want, r_rank, n_rank;
    logic [CW-1:0] r_rr, n_rr;
    logic [TW-1:0] r_tidx, n_tidx, r_tc_idx, n_tc_idx, r_tf_idx, n_tf_idx;
    logic          r_tc, n_tc, r_tf, n_tf;
    t_slot         r_ent, n_ent;
    logic          r_strobe, n_strobe;
    t_result       r_res, n_res;

    // slot RAM
    logic          s_we;
    logic [IW-1:0] s_waddr, s_raddr;
    t_slot         s_wdata, s_q;
    // tie counter RAM: {key, cursor}
    logic          t_we;
    logic [TEW-1:0] t_wdata, t_q;

    gtb_ram #(.WIDTH(SW), .DEPTH(TABLE_ENTRIES)) u_slot_ram (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_q)
    );

    gtb_ram #(.WIDTH(TEW), .DEPTH(TIE_COUNTERS)) u_tie_ram (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(r_tc_idx), .i_wdata(t_wdata),
        .i_raddr(r_tidx), .o_rdata(t_q)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;
    assign s_raddr  = (r_state == S_OUTER) ? r_k : r_idx;

    logic          last, tlast, v, tv, zmatch, pred;
    logic [47:0]   age;
    logic [CW-1:0] want_inc;
    logic [39:0]   key;

    always_comb begin
        last     = (r_idx == IW'(TABLE_ENTRIES - 1));
        tlast    = (r_tidx == TW'(TIE_COUNTERS - 1));
        // valid bit of the slot whose data sits on s_q
        v        = r_valid[s_raddr];
        tv       = r_tvalid[r_tidx];
        key      = {r_in.game_type, r_in.zone_id};
        zmatch   = v && s_q.zone == r_in.zone_id && s_q.gtype == r_in.game_type;
        age      = r_in.time_ms - s_q.hb;
        want_inc = r_want + CW'(1);
        // selection set of the rank search: all live slots, or the least-loaded zone matches
        pred     = (r_in.action == ACT_PICK_RR) ? v : (zmatch && s_q.load == r_best);

        n_state = r_state; n_in = r_in; n_valid = r_valid; n_tvalid = r_tvalid;
        n_count = r_count; n_cursor = r_cursor; n_idx = r_idx; n_k = r_k;
        n_hit_idx = r_hit_idx; n_free_idx = r_free_idx; n_ph = r_ph; n_hit = r_hit;
        n_free = r_free; n_new = r_new; n_any = r_any; n_pass = r_pass; n_best = r_best;
        n_cnt = r_cnt; n_ties = r_ties; n_want = r_want; n_rank = r_rank; n_rr = r_rr;
        n_tidx = r_tidx; n_tc_idx = r_tc_idx; n_tf_idx = r_tf_idx; n_tc = r_tc; n_tf = r_tf;
        n_ent = r_ent; n_strobe = 1'b0; n_res = r_res;
        s_we = 1'b0; s_waddr = r_hit_idx; s_wdata = r_ent;
        t_we = 1'b0; t_wdata = {key, r_rr};

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_in = i_cmd; n_idx = '0; n_ph = 1'b0; n_hit = 1'b0; n_free = 1'b0;
                    n_new = 1'b0; n_any = 1'b0; n_pass = 1'b0; n_cnt = '0; n_ties = '0;
                    n_k = '0; n_res = '0;
                    if (i_cmd.action == ACT_PICK_RR) begin
                        if (r_count == '0) begin
                            n_res.status = ST_MISS; n_strobe = 1'b1;
                        end else begin
                            n_want = r_cursor; n_state = S_OUTER;
                        end
                    end else if (i_cmd.action == ACT_UPSERT || i_cmd.action == ACT_TOUCH ||
                                 i_cmd.action == ACT_PRUNE || i_cmd.action == ACT_PICK_ID ||
                                 i_cmd.action == ACT_PICK_ZN || i_cmd.action == ACT_COUNT) begin
                        n_state = S_SCAN;
                    end else begin
                        n_res.status = ST_MISS; n_strobe = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                n_ph = ~r_ph;
                if (r_ph) begin
                    case (r_in.action)
                        ACT_UPSERT, ACT_TOUCH, ACT_PICK_ID: begin
                            if (v && s_q.id == r_in.gateway_id && !r_hit) begin
                                n_hit = 1'b1; n_hit_idx = r_idx; n_ent = s_q;
                            end
                            if (!v && !r_free) begin
                                n_free = 1'b1; n_free_idx = r_idx;
                            end
                        end
                        ACT_PRUNE: begin
                            if (v && r_in.time_ms > s_q.hb && age > {16'd0, r_timeout}) begin
                                n_valid[r_idx] = 1'b0;
                                n_count = r_count - CW'(1);
                            end
                        end
                        ACT_COUNT: begin
                            if (zmatch) n_cnt = r_cnt + CW'(1);
                        end
                        ACT_PICK_ZN: begin
                            if (!r_pass) begin
                                if (zmatch && (!r_any || s_q.load < r_best)) begin
                                    n_best = s_q.load; n_any = 1'b1;
                                end
                            end else if (zmatch && s_q.load == r_best) begin
                                n_ties = r_ties + CW'(1);
                            end
                        end
                        default: ;
                    endcase
                    if (last) n_state = S_FIN;
                    else n_idx = r_idx + IW'(1);
                end
            end
            S_FIN: begin
                n_res = '0;
                case (r_in.action)
                    ACT_UPSERT: begin
                        if (r_hit) begin
                            n_state = S_WRITE;
                        end else if (r_free) begin
                            n_hit_idx = r_free_idx; n_new = 1'b1; n_state = S_WRITE;
                        end else begin
                            n_res.status = ST_FULL; n_strobe = 1'b1; n_state = S_IDLE;
                        end
                    end
                    ACT_TOUCH: begin
                        if (r_hit) n_state = S_WRITE;
                        else begin
                            n_res.status = ST_MISS; n_strobe = 1'b1; n_state = S_IDLE;
                        end
                    end
                    ACT_PRUNE: n_state = S_WRITE;
                    ACT_PICK_ID: begin
                        n_strobe = 1'b1; n_state = S_IDLE;
                        if (r_hit) begin
                            n_res.status = ST_OK;
                            n_res.picked_id = r_ent.id; n_res.picked_zone = r_ent.zone;
                            n_res.picked_game_type = r_ent.gtype;
                            n_res.picked_online = r_ent.load; n_res.picked_heartbeat = r_ent.hb;
                        end else begin
                            n_res.status = ST_MISS;
                        end
                    end
                    ACT_COUNT: begin
                        n_strobe = 1'b1; n_state = S_IDLE; n_res.status = ST_OK;
                        n_res.zone_count = (32'(r_cnt) > 32'd31) ? 5'd31 : 5'(r_cnt);
                    end
                    ACT_PICK_ZN: begin
                        if (r_pass) begin
                            n_state = S_MOD;
                        end else if (!r_any) begin
                            n_res.status = ST_MISS; n_strobe = 1'b1; n_state = S_IDLE;
                        end else begin
                            n_tidx = '0; n_ph = 1'b0; n_tc = 1'b0; n_tf = 1'b0; n_rr = '0;
                            n_state = S_TIE;
                        end
                    end
                    default: begin
                        n_res.status = ST_MISS; n_strobe = 1'b1; n_state = S_IDLE;
                    end
                endcase
            end
            S_TIE: begin
                n_ph = ~r_ph;
                if (r_ph) begin
                    if (tv && t_q[TEW-1:CW] == key && !r_tc) begin
                        n_tc = 1'b1; n_tc_idx = r_tidx; n_rr = t_q[CW-1:0];
                    end
                    if (!tv && !r_tf) begin
                        n_tf = 1'b1; n_tf_idx = r_tidx;
                    end
                    if (tlast) n_state = S_TFIN;
                    else n_tidx = r_tidx + TW'(1);
                end
            end
            S_TFIN: begin
                // new key takes the lowest free counter; none free: uses 0, not stored
                if (!r_tc && r_tf) begin
                    n_tc = 1'b1; n_tc_idx = r_tf_idx; n_tvalid[r_tf_idx] = 1'b1;
                end
                n_pass = 1'b1; n_idx = '0; n_ph = 1'b0; n_state = S_SCAN;
            end
            S_MOD: begin
                // counter mod ties by repeated subtraction
                if (r_ties <= CW'(1)) begin
                    n_want = '0; n_state = S_OUTER;
                end else if (r_rr >= r_ties) begin
                    n_rr = r_rr - r_ties;
                end else begin
                    n_want = r_rr; n_state = S_OUTER;
                end
                n_k = '0; n_ph = 1'b0;
            end
            S_OUTER: begin
                n_ph = ~r_ph;
                if (r_ph) begin
                    n_ent = s_q;
                    n_idx = '0; n_rank = '0;
                    if (pred) begin
                        n_state = S_INNER;
                    end else if (r_k == IW'(TABLE_ENTRIES - 1)) begin
                        n_res = '0; n_res.status = ST_MISS; n_strobe = 1'b1; n_state = S_IDLE;
                    end else begin
                        n_k = r_k + IW'(1);
                    end
                end
            end
            S_INNER: begin
                n_ph = ~r_ph;
                if (r_ph) begin
                    if (pred && s_q.id < r_ent.id) n_rank = r_rank + CW'(1);
                    if (last) n_state = S_RANK;
                    else n_idx = r_idx + IW'(1);
                end
            end
            S_RANK: begin
                if (r_rank == r_want) begin
                    n_res = '0; n_res.status = ST_OK;
                    n_res.picked_id = r_ent.id; n_res.picked_zone = r_ent.zone;
                    n_res.picked_game_type = r_ent.gtype;
                    n_res.picked_online = r_ent.load; n_res.picked_heartbeat = r_ent.hb;
                    n_strobe = 1'b1; n_state = S_IDLE;
                    if (r_in.action == ACT_PICK_RR) begin
                        n_cursor = (want_inc == r_count) ? '0 : want_inc;
                    end else if (r_tc) begin
                        t_we = 1'b1;
                        if (r_ties > CW'(1))
                            t_wdata = {key, (want_inc == r_ties) ? {CW{1'b0}} : want_inc};
                    end
                end else if (r_k == IW'(TABLE_ENTRIES - 1)) begin
                    n_res = '0; n_res.status = ST_MISS; n_strobe = 1'b1; n_state = S_IDLE;
                end else begin
                    n_k = r_k + IW'(1); n_ph = 1'b0; n_state = S_OUTER;
                end
            end
            S_WRITE: begin
                n_res = '0; n_res.status = ST_OK; n_strobe = 1'b1; n_state = S_IDLE;
                case (r_in.action)
                    ACT_UPSERT: begin
                        s_we = 1'b1;
                        s_wdata = '{id: r_in.gateway_id, zone: r_in.zone_id,
                                    gtype: r_in.game_type, load: r_in.online_count,
                                    hb: r_in.time_ms};
                        n_count = r_count + CW'(r_new);
                        if (r_new) n_valid[r_hit_idx] = 1'b1;
                        if (r_cursor >= n_count) n_cursor = '0;
                    end
                    ACT_TOUCH: begin
                        s_we = 1'b1;
                        s_wdata = r_ent;
                        s_wdata.hb = r_in.time_ms;
                    end
                    default: begin
                        if (r_cursor >= r_count) n_cursor = '0;
                    end
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_valid <= '0; r_tvalid <= '0; r_count <= '0;
            r_cursor <= '0; r_strobe <= 1'b0; r_res <= '0;
            r_timeout <= STALE_TIMEOUT_RST;
        end else begin
            r_state <= n_state; r_valid <= n_valid; r_tvalid <= n_tvalid;
            r_count <= n_count; r_cursor <= n_cursor; r_strobe <= n_strobe; r_res <= n_res;
            if (i_cfg_we) r_timeout <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= n_in; r_idx <= n_idx; r_k <= n_k; r_hit_idx <= n_hit_idx;
        r_free_idx <= n_free_idx; r_ph <= n_ph; r_hit <= n_hit; r_free <= n_free;
        r_new <= n_new; r_any <= n_any; r_pass <= n_pass; r_best <= n_best; r_cnt <= n_cnt;
        r_ties <= n_ties; r_want <= n_want; r_rank <= n_rank; r_rr <= n_rr;
        r_tidx <= n_tidx; r_tc_idx <= n_tc_idx; r_tf_idx <= n_tf_idx; r_tc <= n_tc;
        r_tf <= n_tf; r_ent <= n_ent;
    end
endmodule

// ----- rtl/gtb_checker.sv -----
// Port-level checker for the gateway table balancer, bound to the top level.
// Depends on gtb_pkg and gateway_table_balancer.
module gtb_checker
    import gtb_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_strobe,
    input t_result o_result
);
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy || start)) else $error("result without work");

    // short commands answer in the next cycle without raising busy
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_strobe) else $error("transfer not taken");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && !start |=> !o_strobe) else $error("spurious result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_result.status != 2'd3) else $error("bad status");

    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.status != ST_OK |->
            o_result.picked_id == '0 && o_result.zone_count == '0)
        else $error("fields not cleared");
endmodule

bind gateway_table_balancer gtb_checker u_gtb_checker (.*);
